// ===== rtl/btcd_pkg.sv =====
// btcd_pkg: shared types and constants for the breath trigger / cycle detector
// no dependencies; used by the interfaces, the hold timer and the top level
`default_nettype none

package btcd_pkg;

  // fixed field widths
  localparam int unsigned PEEP_BITS  = 9;
  localparam int unsigned SENS_BITS  = 9;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned CFG_BITS   = 9;
  localparam int unsigned PRES_BITS  = 11;
  localparam int unsigned FLOW_BITS  = 13;
  localparam int unsigned PEAK_BITS  = 12;

  // timing spans in ms
  localparam int unsigned BLANK_MS = 200;
  localparam int unsigned HOLD_MS  = 50;

  // register reset values
  localparam logic [PEEP_BITS-1:0] PEEP_RESET = 9'd50;

  typedef enum logic [1:0] {
    CFG_PEEP_LEVEL  = 2'd0,
    CFG_PRESS_SENS  = 2'd1,
    CFG_FLOW_SENS   = 2'd2,
    CFG_CYCLE_FRAC  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PHASE_INSP  = 2'd0,
    PHASE_EXP   = 2'd1,
    PHASE_OTHER = 2'd2,
    PHASE_SPARE = 2'd3
  } phase_e;

  localparam logic [1:0] MODE_NON_PSV = 2'd0;

  // request to one hold timer for the beat in flight
  typedef struct packed {
    logic en;
    logic cond;
  } hold_req_t;

endpackage

`default_nettype wire

// ===== rtl/btcd_if.sv =====
// btcd channel interfaces: sample input, result output, configuration writes
// depends on btcd_pkg
`default_nettype none

interface btcd_sample_if #(
  parameter int unsigned TIME_BITS = 32
);
  logic                                   valid;
  logic                                   ready;
  logic [TIME_BITS-1:0]                   now_ms;
  logic [1:0]                             phase;
  logic [TIME_BITS-1:0]                   phase_start_ms;
  logic [1:0]                             vent_mode;
  logic signed [btcd_pkg::PRES_BITS-1:0]  pressure;
  logic signed [btcd_pkg::FLOW_BITS-1:0]  patient_flow;
  logic [btcd_pkg::PEAK_BITS-1:0]         peak_insp_flow;

  modport source (
    output valid, now_ms, phase, phase_start_ms, vent_mode, pressure, patient_flow,
           peak_insp_flow,
    input  ready
  );
  modport sink (
    input  valid, now_ms, phase, phase_start_ms, vent_mode, pressure, patient_flow,
           peak_insp_flow,
    output ready
  );
endinterface

interface btcd_result_if;
  logic valid;
  logic ready;
  logic trigger_detected;
  logic cycle_detected;

  modport source (output valid, trigger_detected, cycle_detected, input ready);
  modport sink (input valid, trigger_detected, cycle_detected, output ready);
endinterface

interface btcd_cfg_if;
  logic                              valid;
  logic                              ready;
  btcd_pkg::cfg_reg_e                index;
  logic [btcd_pkg::CFG_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/btcd_hold_timer.sv =====
// btcd_hold_timer: armed flag plus start time for one 50 ms hold condition
// depends on btcd_pkg
`default_nettype none

module btcd_hold_timer #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire btcd_pkg::hold_req_t  req,
  input  wire logic [TIME_BITS-1:0] now,
  output logic                      fire
);

  logic                 armed;
  logic [TIME_BITS-1:0] start;
  logic [TIME_BITS-1:0] held;

  assign held = now - start;
  assign fire = req.en && req.cond && armed && (held >= TIME_BITS'(btcd_pkg::HOLD_MS));

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
    end else if (req.en) begin
      if (!req.cond) begin
        armed <= 1'b0;
      end else if (!armed) begin
        armed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && req.cond && !armed) begin
      start <= now;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/breath_trigger_cycle_detector_core.sv =====
// breath_trigger_cycle_detector_core: top level of the trigger / cycle detector
// depends on btcd_pkg, btcd_if and btcd_hold_timer
`default_nettype none

// One sensor sample in, one result out, one sample per clock sustained while
// the result side takes results. A sample is captured in an input register,
// evaluated against the three hold timers and written to a result register
// once the result slot is free. While a result waits, the input register can
// still take one more sample; the input stalls only when that register is
// full and the result is still held. The single compare/multiply stage between
// the two registers updates the timer state in the same cycle as the result
// register is written, so the next sample sees it. Configuration writes are
// taken in any cycle (ready is always high) and should be made while no
// sample is in flight.
module breath_trigger_cycle_detector_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input wire logic        clk,
  input wire logic        rst,
  btcd_cfg_if.sink        cfg,
  btcd_sample_if.sink     sample,
  btcd_result_if.source   result
);

  // configuration registers
  logic [btcd_pkg::PEEP_BITS-1:0]        peep_level;
  logic signed [btcd_pkg::SENS_BITS-1:0] press_sens;
  logic [btcd_pkg::SENS_BITS-1:0]        flow_sens;
  logic [btcd_pkg::FRAC_BITS-1:0]        cycle_frac;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      peep_level <= btcd_pkg::PEEP_RESET;
      press_sens <= '0;
      flow_sens  <= '0;
      cycle_frac <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        btcd_pkg::CFG_PEEP_LEVEL: peep_level <= cfg.data;
        btcd_pkg::CFG_PRESS_SENS: press_sens <= cfg.data;
        btcd_pkg::CFG_FLOW_SENS:  flow_sens  <= cfg.data;
        btcd_pkg::CFG_CYCLE_FRAC: cycle_frac <= cfg.data[btcd_pkg::FRAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                                   s1_valid;
  logic [TIME_BITS-1:0]                   s1_now;
  logic [1:0]                             s1_phase;
  logic [TIME_BITS-1:0]                   s1_pstart;
  logic [1:0]                             s1_mode;
  logic signed [btcd_pkg::PRES_BITS-1:0]  s1_pres;
  logic signed [btcd_pkg::FLOW_BITS-1:0]  s1_flow;
  logic [btcd_pkg::PEAK_BITS-1:0]         s1_peak;

  logic out_free;
  logic step;

  assign out_free     = !result.valid || result.ready;
  assign step         = s1_valid && out_free;
  assign sample.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_now    <= sample.now_ms;
      s1_phase  <= sample.phase;
      s1_pstart <= sample.phase_start_ms;
      s1_mode   <= sample.vent_mode;
      s1_pres   <= sample.pressure;
      s1_flow   <= sample.patient_flow;
      s1_peak   <= sample.peak_insp_flow;
    end
  end

  // evaluation
  logic [TIME_BITS-1:0]                   elapsed;
  logic                                   blank_ok;
  logic                                   exp_gate;
  logic                                   cyc_gate;
  logic signed [btcd_pkg::PRES_BITS-1:0]  press_thr;
  logic [19:0]                            cyc_rhs;
  logic signed [21:0]                     cyc_lhs_x;
  logic signed [21:0]                     cyc_rhs_x;
  btcd_pkg::hold_req_t                    press_req;
  btcd_pkg::hold_req_t                    flow_req;
  btcd_pkg::hold_req_t                    cyc_req;
  logic                                   press_fire;
  logic                                   flow_fire;
  logic                                   cyc_fire;

  assign elapsed  = s1_now - s1_pstart;
  assign blank_ok = elapsed >= TIME_BITS'(btcd_pkg::BLANK_MS);
  assign exp_gate = (s1_phase == btcd_pkg::PHASE_EXP) && blank_ok;
  assign cyc_gate = (s1_mode != btcd_pkg::MODE_NON_PSV) && (s1_phase == btcd_pkg::PHASE_INSP)
                    && blank_ok && (cycle_frac != '0) && (s1_peak != '0);

  assign press_thr = $signed({2'b00, peep_level}) + $signed({{2{press_sens[8]}}, press_sens});
  assign cyc_rhs   = cycle_frac * s1_peak;
  assign cyc_lhs_x = $signed({s1_flow[btcd_pkg::FLOW_BITS-1], s1_flow, 8'b0});
  assign cyc_rhs_x = $signed({2'b00, cyc_rhs});

  assign press_req.en   = step && exp_gate && press_sens[btcd_pkg::SENS_BITS-1];
  assign press_req.cond = s1_pres < press_thr;
  assign flow_req.en    = step && exp_gate && !press_fire && (flow_sens != '0);
  assign flow_req.cond  = s1_flow > $signed({4'b0000, flow_sens});
  assign cyc_req.en     = step && cyc_gate;
  assign cyc_req.cond   = cyc_lhs_x < cyc_rhs_x;

  btcd_hold_timer #(.TIME_BITS(TIME_BITS)) u_press_timer (
    .clk(clk), .rst(rst), .req(press_req), .now(s1_now), .fire(press_fire)
  );

  btcd_hold_timer #(.TIME_BITS(TIME_BITS)) u_flow_timer (
    .clk(clk), .rst(rst), .req(flow_req), .now(s1_now), .fire(flow_fire)
  );

  btcd_hold_timer #(.TIME_BITS(TIME_BITS)) u_cycle_timer (
    .clk(clk), .rst(rst), .req(cyc_req), .now(s1_now), .fire(cyc_fire)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (step) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.trigger_detected <= press_fire || flow_fire;
      result.cycle_detected   <= cyc_fire;
    end
  end

`ifndef SYNTHESIS
  a_no_trig_and_cycle: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.trigger_detected && result.cycle_detected))
    else $error("trigger and cycle reported in the same beat");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("input stalled while result slot is empty");

  a_flow_skipped_on_press: assert property (@(posedge clk) disable iff (rst)
    press_fire |-> !flow_req.en)
    else $error("flow timer touched after pressure trigger fired");

  a_step_fills_result: assert property (@(posedge clk) disable iff (rst)
    step |=> result.valid)
    else $error("evaluated beat did not reach the result register");
`endif

endmodule

`default_nettype wire

// ===== verif/btcd_detect_checker.sv =====
// btcd_detect_checker: watches the config, sample and result channels of the
// breath trigger / cycle detector, predicts each result beat and compares it
// depends on btcd_pkg and btcd_if
`default_nettype none

module btcd_detect_checker
  import btcd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input wire logic clk,
  input wire logic rst,
  btcd_cfg_if      cfg,
  btcd_sample_if   sample,
  btcd_result_if   result,
  output int       fail_count,
  output int       pending,
  output int       n_results,
  output int       n_trig,
  output int       n_cyc
);

  localparam int TMR_PRESS = 0;
  localparam int TMR_FLOW  = 1;
  localparam int TMR_CYCLE = 2;

  typedef struct packed {
    logic trig;
    logic cyc;
  } detect_t;

  logic [PEEP_BITS-1:0]        peep;
  logic signed [SENS_BITS-1:0] press_sens;
  logic [CFG_BITS-1:0]         flow_sens;
  logic [FRAC_BITS-1:0]        frac;
  logic                        armed [3];
  logic [TIME_BITS-1:0]        since [3];

  detect_t expected_q [$];
  detect_t want;
  detect_t got;
  int      errs;
  int      seen;
  int      trigs;
  int      cycs;

  function automatic logic span_passed(input logic [TIME_BITS-1:0] later,
                                       input logic [TIME_BITS-1:0] earlier,
                                       input int unsigned span);
    logic [TIME_BITS-1:0] gap;
    gap = later - earlier;
    return gap >= span;
  endfunction

  // one hold timer: arm on first hit, fire once held long enough
  function automatic logic hold_step(input int id, input logic cond,
                                     input logic [TIME_BITS-1:0] now);
    if (!cond) begin
      armed[id] = 1'b0;
      return 1'b0;
    end
    if (armed[id]) begin
      return span_passed(now, since[id], HOLD_MS);
    end
    armed[id] = 1'b1;
    since[id] = now;
    return 1'b0;
  endfunction

  function automatic detect_t predict_detect(input logic [TIME_BITS-1:0] now,
                                             input logic [1:0] ph,
                                             input logic [TIME_BITS-1:0] pstart,
                                             input logic [1:0] mode,
                                             input logic signed [PRES_BITS-1:0] pres,
                                             input logic signed [FLOW_BITS-1:0] flow,
                                             input logic [PEAK_BITS-1:0] peak);
    detect_t d;
    logic    blank_done;
    d = '0;
    blank_done = span_passed(now, pstart, BLANK_MS);
    if (ph == PHASE_EXP && blank_done) begin
      if (press_sens < 0) begin
        d.trig = hold_step(TMR_PRESS, int'(pres) < int'(peep) + int'(press_sens), now);
      end
      // pressure firing skips the flow timer entirely
      if (!d.trig && flow_sens != 0) begin
        d.trig = hold_step(TMR_FLOW, int'(flow) > int'(flow_sens), now);
      end
    end
    if (ph == PHASE_INSP && mode != MODE_NON_PSV && blank_done && frac != 0 && peak != 0) begin
      d.cyc = hold_step(TMR_CYCLE, int'(flow) * 256 < int'(frac) * int'(peak), now);
    end
    return d;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      peep       = PEEP_RESET;
      press_sens = '0;
      flow_sens  = '0;
      frac       = '0;
      for (int i = 0; i < 3; i++) begin
        armed[i] = 1'b0;
        since[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_PEEP_LEVEL: peep = cfg.data;
          CFG_PRESS_SENS: press_sens = cfg.data;
          CFG_FLOW_SENS:  flow_sens = cfg.data;
          CFG_CYCLE_FRAC: frac = cfg.data[FRAC_BITS-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        got.trig = result.trigger_detected;
        got.cyc  = result.cycle_detected;
        seen++;
        trigs += got.trig;
        cycs  += got.cyc;
        if (expected_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result beat: expected none, actual trig %b cyc %b",
                   $time, got.trig, got.cyc);
        end else begin
          want = expected_q.pop_front();
          if (got.trig !== want.trig || got.cyc !== want.cyc) begin
            errs++;
            $display("%0t: result mismatch: expected trig %b cyc %b, actual trig %b cyc %b",
                     $time, want.trig, want.cyc, got.trig, got.cyc);
          end
        end
      end
      if (sample.valid && sample.ready) begin
        expected_q.push_back(predict_detect(sample.now_ms, sample.phase, sample.phase_start_ms,
                                            sample.vent_mode, sample.pressure,
                                            sample.patient_flow, sample.peak_insp_flow));
      end
    end
    fail_count <= errs;
    pending    <= expected_q.size();
    n_results  <= seen;
    n_trig     <= trigs;
    n_cyc      <= cycs;
  end

endmodule

`default_nettype wire

// ===== verif/tb_breath_trigger_cycle_detector_core.sv =====
// tb_breath_trigger_cycle_detector_core: drives sensor samples, register writes
// and result back-pressure into the detector and reports the verdict
// depends on btcd_pkg, btcd_if, btcd_detect_checker and the core
`default_nettype none

module tb_breath_trigger_cycle_detector_core;
  import btcd_pkg::*;

  localparam int unsigned TIME_BITS      = 32;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLDOFF_CYCLES = 300;
  localparam int          RAND_PHASES    = 8;
  localparam int          PHASE_ITEMS    = 60;

  localparam logic [1:0] MODE_PSV      = 2'd1;
  localparam logic [1:0] MODE_SIMV_VCV = 2'd2;
  localparam logic [1:0] MODE_SIMV_PCV = 2'd3;

  logic clk;
  logic rst;

  btcd_cfg_if                             cfg_ch ();
  btcd_sample_if #(.TIME_BITS(TIME_BITS)) sample_ch ();
  btcd_result_if                          result_ch ();

  int fail_count;
  int pending;
  int n_results;
  int n_trig;
  int n_cyc;

  int   n_sent;
  int   n_settings;
  int   idle_cycles;
  int   holdoff_req;
  int   holdoff_done;
  logic tx_idle_en;
  logic rx_idle_en;

  // stimulus copy of the register values, used to aim samples at thresholds
  int peep_set;
  int sens_set;
  int flow_set;
  int frac_set;

  breath_trigger_cycle_detector_core #(.TIME_BITS(TIME_BITS)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (sample_ch),
    .result (result_ch)
  );

  btcd_detect_checker #(.TIME_BITS(TIME_BITS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .sample     (sample_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .n_results  (n_results),
    .n_trig     (n_trig),
    .n_cyc      (n_cyc)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req != holdoff_done) begin
        holdoff_done = holdoff_req;
        result_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) begin
          @(posedge clk);
          result_ch.ready <= 1'b0;
        end
      end else if (rx_idle_en) begin
        result_ch.ready <= ($urandom_range(99) >= 29);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int clamp(input int v, input int lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[CFG_BITS-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_setting(input int peep, input int sens, input int flow, input int frac);
    write_reg(CFG_PEEP_LEVEL, peep);
    write_reg(CFG_PRESS_SENS, sens);
    write_reg(CFG_FLOW_SENS, flow);
    write_reg(CFG_CYCLE_FRAC, frac);
    cfg_ch.valid <= 1'b0;
    peep_set = peep;
    sens_set = sens;
    flow_set = flow;
    frac_set = frac;
    n_settings++;
  endtask

  task automatic send_sample(input logic [TIME_BITS-1:0] now, input logic [1:0] ph,
                             input logic [TIME_BITS-1:0] pstart, input logic [1:0] mode,
                             input int pres, input int flow, input int peak);
    while (tx_idle_en && $urandom_range(99) < 29) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.now_ms         <= now;
    sample_ch.phase          <= ph;
    sample_ch.phase_start_ms <= pstart;
    sample_ch.vent_mode      <= mode;
    sample_ch.pressure       <= pres[PRES_BITS-1:0];
    sample_ch.patient_flow   <= flow[FLOW_BITS-1:0];
    sample_ch.peak_insp_flow <= peak[PEAK_BITS-1:0];
    do @(posedge clk); while (!sample_ch.ready);
    n_sent++;
  endtask

  // wait until every result beat is back and the core is quiet
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // breath-like sample stream: rising time, phases that alternate, values
  // near the configured thresholds, with some fully random samples mixed in
  task automatic run_breaths(input int n_items, input int noise_pct,
                             input logic [TIME_BITS-1:0] t0);
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] pstart;
    phase_e               ph;
    logic [1:0]           mode;
    int                   peak;
    int                   plen;
    int                   thr;
    int                   lim;
    int                   pres;
    int                   flow;
    logic                 cp;
    logic                 cf;
    logic                 cc;
    t      = t0;
    pstart = t0;
    ph     = PHASE_EXP;
    mode   = MODE_PSV;
    peak   = 1000;
    plen   = 600;
    cp     = 1'b0;
    cf     = 1'b0;
    cc     = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        send_sample($urandom, 2'($urandom_range(3)), $urandom, 2'($urandom_range(3)),
                    $urandom, $urandom, $urandom);
      end else begin
        t = t + $urandom_range(25);
        if (t - pstart >= plen) begin
          pstart = t;
          plen   = $urandom_range(900, 250);
          case (ph)
            PHASE_INSP: ph = PHASE_EXP;
            PHASE_EXP:  ph = ($urandom_range(9) == 0) ? PHASE_OTHER : PHASE_INSP;
            default:    ph = PHASE_INSP;
          endcase
          mode = 2'($urandom_range(3));
          peak = ($urandom_range(15) == 0) ? 0 : $urandom_range(3000, 1);
        end
        if ($urandom_range(7) == 0) cp = ~cp;
        if ($urandom_range(7) == 0) cf = ~cf;
        if ($urandom_range(7) == 0) cc = ~cc;
        thr  = peep_set + sens_set;
        pres = cp ? thr - int'($urandom_range(40, 1)) : thr + int'($urandom_range(40));
        if (ph == PHASE_INSP) begin
          lim  = frac_set * peak / 256;
          flow = cc ? lim - int'($urandom_range(40, 1)) : lim + int'($urandom_range(40));
        end else begin
          flow = cf ? flow_set + int'($urandom_range(40, 1)) : flow_set - int'($urandom_range(40));
        end
        send_sample(t, ph, pstart, mode, clamp(pres, 1000), clamp(flow, 3000), peak);
      end
    end
    sample_ch.valid <= 1'b0;
  endtask

  initial begin
    n_sent       = 0;
    n_settings   = 0;
    holdoff_req  = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    rst                      <= 1'b1;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.index             <= CFG_PEEP_LEVEL;
    cfg_ch.data              <= '0;
    sample_ch.valid          <= 1'b0;
    sample_ch.now_ms         <= '0;
    sample_ch.phase          <= PHASE_INSP;
    sample_ch.phase_start_ms <= '0;
    sample_ch.vent_mode      <= MODE_NON_PSV;
    sample_ch.pressure       <= '0;
    sample_ch.patient_flow   <= '0;
    sample_ch.peak_insp_flow <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: pressure threshold 30, flow threshold 30, cycle at half of peak
    apply_setting(50, -20, 30, 128);
    // expiration: blanking, pressure arm and hold, flow takeover
    send_sample(32'd1100, PHASE_EXP, 32'd1000, MODE_PSV, 0, 0, 0);
    send_sample(32'd1200, PHASE_EXP, 32'd1000, MODE_PSV, 0, 0, 0);
    send_sample(32'd1249, PHASE_EXP, 32'd1000, MODE_PSV, 0, 0, 0);
    send_sample(32'd1250, PHASE_EXP, 32'd1000, MODE_PSV, 0, 0, 0);
    send_sample(32'd1260, PHASE_EXP, 32'd1000, MODE_PSV, 100, 100, 0);
    send_sample(32'd1310, PHASE_EXP, 32'd1000, MODE_PSV, 100, 100, 0);
    send_sample(32'd1320, PHASE_EXP, 32'd1000, MODE_PSV, -1024, 4095, 0);
    send_sample(32'd1380, PHASE_EXP, 32'd1000, MODE_PSV, 1023, -4096, 0);
    // inspiration: cycling, zero peak, non-psv mode, other phase codes
    send_sample(32'd2150, PHASE_INSP, 32'd2000, MODE_PSV, 0, 100, 1000);
    send_sample(32'd2200, PHASE_INSP, 32'd2000, MODE_PSV, 0, 100, 1000);
    send_sample(32'd2250, PHASE_INSP, 32'd2000, MODE_PSV, 0, 100, 1000);
    send_sample(32'd2260, PHASE_INSP, 32'd2000, MODE_PSV, 0, 100, 0);
    send_sample(32'd2270, PHASE_INSP, 32'd2000, MODE_PSV, 0, 100, 4095);
    send_sample(32'd2280, PHASE_INSP, 32'd2000, MODE_PSV, 0, 4095, 4095);
    send_sample(32'd2290, PHASE_INSP, 32'd2000, MODE_NON_PSV, 0, 0, 1000);
    send_sample(32'd2300, PHASE_INSP, 32'd2000, MODE_SIMV_PCV, 0, -4096, 1000);
    send_sample(32'd2360, PHASE_INSP, 32'd2000, MODE_SIMV_VCV, 0, -4096, 1000);
    send_sample(32'd2400, PHASE_OTHER, 32'd2000, MODE_PSV, -1024, 4095, 1000);
    send_sample(32'd2410, PHASE_SPARE, 32'd0, MODE_SIMV_PCV, -1024, 4095, 4095);
    // time counter wrap across blanking and hold
    send_sample(32'h0000_0048, PHASE_EXP, 32'hFFFF_FF80, MODE_PSV, -1024, 0, 0);
    send_sample(32'h0000_007A, PHASE_EXP, 32'hFFFF_FF80, MODE_PSV, -1024, 0, 0);
    send_sample(32'hFFFF_FFFF, PHASE_EXP, 32'h0000_0000, MODE_PSV, -1024, 0, 0);
    sample_ch.valid <= 1'b0;
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      tx_idle_en = (p > 1);
      rx_idle_en = (p > 1);
      case (p)
        0: apply_setting(500, -200, 300, 255);
        1: apply_setting(0, -1, 1, 1);
        2: apply_setting(50, 0, 0, 0);
        3: apply_setting(250, 100, 150, 77);
        default: apply_setting($urandom_range(500), -int'($urandom_range(200)),
                               $urandom_range(300), $urandom_range(255));
      endcase
      // result side holds off while samples keep coming, so the core backs up
      if (p == 1) holdoff_req++;
      run_breaths(PHASE_ITEMS, 10, (p == 2) ? 32'hFFFF_FC00 : $urandom);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d samples under %0d register settings incl. extremes and disabled",
             n_sent, n_settings);
    $display("%0d result beats checked, %0d with trigger and %0d with cycle end",
             n_results, n_trig, n_cyc);
    if (pending != 0) $display("%0t: %0d result beats never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/btcd_pkg.sv
rtl/btcd_if.sv
rtl/btcd_hold_timer.sv
rtl/breath_trigger_cycle_detector_core.sv
verif/btcd_detect_checker.sv
verif/tb_breath_trigger_cycle_detector_core.sv
